[rtl/core/svta_pkg.sv]
package svta_pkg;

  // Angular resolution and derived sizes
  localparam int ANGLE_STEPS = 90;
  localparam int SIDE        = ANGLE_STEPS + 1;
  localparam int ANG_W       = $clog2(SIDE);
  localparam int IDX_W       = $clog2(SIDE * SIDE);

  // Fixed field widths
  localparam int IN_W   = 16;
  localparam int OUT_W  = 7;
  localparam int COMP_W = 14;   // stored components never exceed 10000
  localparam int Q30_W  = 31;   // Q30 values run 0 .. 2^30

  // Exact flat-index to row split: row = (idx * RECIP) >> RECIP_SH
  localparam int RECIP_SH = IDX_W + ANG_W;
  localparam int RECIP_W  = IDX_W + 2;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + SIDE - 1) / SIDE);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] SCALE       = 64'd10000;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_MUL,
    ST_ROW_CMP,
    ST_COL_INIT,
    ST_COL_MUL,
    ST_COL_CMP,
    ST_FINISH
  } svta_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic probe_mul;
    logic probe_cmp;
    logic col_phase;
    logic start_col;
    logic load_out;
  } svta_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic search_done;
  } svta_sts_t;

  function automatic logic [Q30_W-1:0] clamp_q30(longint v);
    if (v < 0) return '0;
    if (v > longint'(ONE_Q30)) return Q30_W'(ONE_Q30);
    return Q30_W'(v);
  endfunction

  // Eight-term sine series in Q30
  function automatic logic [Q30_W-1:0] taylor_sin(logic [63:0] th);
    logic [63:0] t2;
    logic [63:0] term;
    longint      acc;
    t2   = (th * th) >> 30;
    term = th;
    acc  = longint'(th);
    term = ((term * t2) >> 30) / 6;   acc = acc - longint'(term);
    term = ((term * t2) >> 30) / 20;  acc = acc + longint'(term);
    term = ((term * t2) >> 30) / 42;  acc = acc - longint'(term);
    term = ((term * t2) >> 30) / 72;  acc = acc + longint'(term);
    term = ((term * t2) >> 30) / 110; acc = acc - longint'(term);
    term = ((term * t2) >> 30) / 156; acc = acc + longint'(term);
    term = ((term * t2) >> 30) / 210; acc = acc - longint'(term);
    return clamp_q30(acc);
  endfunction

  // Eight-term cosine series in Q30
  function automatic logic [Q30_W-1:0] taylor_cos(logic [63:0] th);
    logic [63:0] t2;
    logic [63:0] term;
    longint      acc;
    t2   = (th * th) >> 30;
    term = ONE_Q30;
    acc  = longint'(ONE_Q30);
    term = ((term * t2) >> 30) / 2;   acc = acc - longint'(term);
    term = ((term * t2) >> 30) / 12;  acc = acc + longint'(term);
    term = ((term * t2) >> 30) / 30;  acc = acc - longint'(term);
    term = ((term * t2) >> 30) / 56;  acc = acc + longint'(term);
    term = ((term * t2) >> 30) / 90;  acc = acc - longint'(term);
    term = ((term * t2) >> 30) / 132; acc = acc + longint'(term);
    term = ((term * t2) >> 30) / 182; acc = acc - longint'(term);
    return clamp_q30(acc);
  endfunction

  // Per-angle sine and cosine; upper half mirrored from the lower half
  function automatic logic [Q30_W-1:0] sin_q_at(int k);
    logic [63:0] th;
    if (2 * k <= ANGLE_STEPS) begin
      th = (64'(k) * HALF_PI_Q30) / ANGLE_STEPS;
      return taylor_sin(th);
    end
    th = (64'(ANGLE_STEPS - k) * HALF_PI_Q30) / ANGLE_STEPS;
    return taylor_cos(th);
  endfunction

  function automatic logic [Q30_W-1:0] cos_q_at(int k);
    logic [63:0] th;
    if (2 * k <= ANGLE_STEPS) begin
      th = (64'(k) * HALF_PI_Q30) / ANGLE_STEPS;
      return taylor_cos(th);
    end
    th = (64'(ANGLE_STEPS - k) * HALF_PI_Q30) / ANGLE_STEPS;
    return taylor_sin(th);
  endfunction

  function automatic logic [COMP_W-1:0] row_y_at(int k);
    logic [63:0] p;
    p = (SCALE * 64'(sin_q_at(k))) >> 30;
    return COMP_W'(p);
  endfunction

  function automatic logic [COMP_W-1:0] row_x_at(int k);
    logic [63:0] p;
    p = (SCALE * 64'(cos_q_at(k))) >> 30;
    return COMP_W'(p);
  endfunction

endpackage

[rtl/core/svta_if.sv]
// Direction request channel
interface svta_in_if;
  import svta_pkg::*;
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] x_component;
  logic [IN_W-1:0] y_component;
  logic [IN_W-1:0] z_component;
  modport source (output valid, output x_component, output y_component,
                  output z_component, input ready);
  modport sink   (input valid, input x_component, input y_component,
                  input z_component, output ready);
endinterface

// Angle result channel
interface svta_out_if;
  import svta_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] angle_z;
  logic [OUT_W-1:0] angle_y;
  modport source (output valid, output angle_z, output angle_y, input ready);
  modport sink   (input valid, input angle_z, input angle_y, output ready);
endinterface

[rtl/core/svta_ctrl.sv]
module svta_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  svta_pkg::svta_sts_t sts,
  output svta_pkg::svta_cmd_t cmd
);
  import svta_pkg::*;

  svta_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_ROW_MUL;
        end
      end
      ST_ROW_MUL: begin
        cmd.probe_mul = 1'b1;
        state_nxt     = ST_ROW_CMP;
      end
      ST_ROW_CMP: begin
        cmd.probe_cmp = 1'b1;
        state_nxt     = sts.search_done ? ST_COL_INIT : ST_ROW_MUL;
      end
      ST_COL_INIT: begin
        cmd.start_col = 1'b1;
        state_nxt     = ST_COL_MUL;
      end
      ST_COL_MUL: begin
        cmd.probe_mul = 1'b1;
        cmd.col_phase = 1'b1;
        state_nxt     = ST_COL_CMP;
      end
      ST_COL_CMP: begin
        cmd.probe_cmp = 1'b1;
        cmd.col_phase = 1'b1;
        state_nxt     = sts.search_done ? ST_FINISH : ST_COL_MUL;
      end
      ST_FINISH: begin
        // hand over once the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  // Checks
  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending one");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result valid raised outside finish");

  a_row_then_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROW_CMP && sts.search_done) |=> (state_r == ST_COL_INIT))
    else $error("row search end not followed by column set-up");

  a_col_probe_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COL_MUL) |=> (state_r == ST_COL_CMP))
    else $error("column multiply not followed by compare");

endmodule

[rtl/core/svta_dpath.sv]
module svta_dpath (
  input  logic                          clk,
  input  svta_pkg::svta_cmd_t           cmd,
  input  logic [svta_pkg::IN_W-1:0]     in_x,
  input  logic [svta_pkg::IN_W-1:0]     in_y,
  input  logic [svta_pkg::IN_W-1:0]     in_z,
  output svta_pkg::svta_sts_t           sts,
  output logic [svta_pkg::OUT_W-1:0]    out_angle_z,
  output logic [svta_pkg::OUT_W-1:0]    out_angle_y
);
  import svta_pkg::*;

  localparam int PROD_W = IDX_W + RECIP_W;
  localparam int XP_W   = COMP_W + Q30_W;

  // Per-angle constant tables
  logic [COMP_W-1:0] row_y_lut [SIDE];
  logic [COMP_W-1:0] row_x_lut [SIDE];
  logic [Q30_W-1:0]  sin_lut   [SIDE];
  logic [Q30_W-1:0]  cos_lut   [SIDE];

  for (genvar k = 0; k < SIDE; k++) begin : g_lut
    localparam logic [COMP_W-1:0] RY = row_y_at(k);
    localparam logic [COMP_W-1:0] RX = row_x_at(k);
    localparam logic [Q30_W-1:0]  SQ = sin_q_at(k);
    localparam logic [Q30_W-1:0]  CQ = cos_q_at(k);
    assign row_y_lut[k] = RY;
    assign row_x_lut[k] = RX;
    assign sin_lut[k]   = SQ;
    assign cos_lut[k]   = CQ;
  end

  logic [IN_W-1:0]   x_in_r, y_in_r, z_in_r;
  logic [IDX_W-1:0]  top_r, bot_r, prev_r, mid_r;
  logic              have_prev_r;
  logic [ANG_W-1:0]  top_row_r, row_r;
  logic [PROD_W-1:0] rprod_r;
  logic [XP_W-1:0]   xprod_r, zprod_r;
  logic [OUT_W-1:0]  out_z_r, out_y_r;

  // Midpoint of the live range
  logic [IDX_W:0]   mid_sum;
  logic [IDX_W-1:0] mid;
  logic [ANG_W-1:0] mid_col;
  assign mid_sum = {1'b0, top_r} + {1'b0, bot_r};
  assign mid     = mid_sum[IDX_W:1];
  assign mid_col = mid[ANG_W-1:0];

  // Probe compare: row phase tests y only, column phase tests z then x
  logic [ANG_W-1:0]  r_probe;
  logic [COMP_W-1:0] x_e, z_e;
  logic              row_lt, col_lt, key_lt;
  assign r_probe = rprod_r[RECIP_SH +: ANG_W];
  assign x_e     = xprod_r[30 +: COMP_W];
  assign z_e     = zprod_r[30 +: COMP_W];
  assign row_lt  = IN_W'(row_y_lut[r_probe]) < y_in_r;
  assign col_lt  = {IN_W'(z_e), IN_W'(x_e)} < {z_in_r, x_in_r};
  assign key_lt  = cmd.col_phase ? col_lt : row_lt;

  assign sts.search_done = have_prev_r && (prev_r == mid_r);

  // Search registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_in_r      <= in_x;
      y_in_r      <= in_y;
      z_in_r      <= in_z;
      top_r       <= '0;
      bot_r       <= IDX_W'(SIDE * SIDE - 1);
      have_prev_r <= 1'b0;
      top_row_r   <= '0;
    end else if (cmd.start_col) begin
      row_r       <= top_row_r;
      top_r       <= '0;
      bot_r       <= IDX_W'(SIDE - 1);
      have_prev_r <= 1'b0;
    end else if (cmd.probe_cmp) begin
      if (key_lt) begin
        top_r <= mid_r;
        if (!cmd.col_phase) top_row_r <= r_probe;
      end else begin
        bot_r <= mid_r;
      end
      prev_r      <= mid_r;
      have_prev_r <= 1'b1;
    end
  end

  // Probe multiply: row split in row phase, point components in column phase
  always_ff @(posedge clk) begin
    if (cmd.probe_mul) begin
      mid_r <= mid;
      if (cmd.col_phase) begin
        xprod_r <= XP_W'(row_x_lut[row_r]) * XP_W'(cos_lut[mid_col]);
        zprod_r <= XP_W'(row_x_lut[row_r]) * XP_W'(sin_lut[mid_col]);
      end else begin
        rprod_r <= PROD_W'(mid) * PROD_W'(RECIP);
      end
    end
  end

  // Result register
  logic [ANG_W+OUT_W-1:0] z_ext, y_ext;
  assign z_ext = {{OUT_W{1'b0}}, row_r};
  assign y_ext = {{OUT_W{1'b0}}, top_r[ANG_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_z_r <= z_ext[OUT_W-1:0];
      out_y_r <= y_ext[OUT_W-1:0];
    end
  end

  assign out_angle_z = out_z_r;
  assign out_angle_y = out_y_r;

endmodule

[rtl/core/sphere_vector_to_angles_unit.sv]
// Each request runs a row search of Pr probes (14 to 16) and then a column search of
// Pc probes (7 to 9); each probe is a ROM multiply then a key compare, and probes of one
// request run strictly in order. A new request is accepted only in idle, after the
// previous result has been loaded into the output register.
// Reset: synchronous active-low rst_n returns the controller to idle with no result pending;
// the angle tables are constants and need no fill.
module sphere_vector_to_angles_unit (
  input  logic       clk,
  input  logic       rst_n,
  svta_in_if.sink    in_chan,
  svta_out_if.source out_chan
);
  import svta_pkg::*;

  svta_cmd_t cmd;
  svta_sts_t sts;

  // Search sequencer
  svta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Search datapath and angle tables
  svta_dpath u_dpath (
    .clk         (clk),
    .cmd         (cmd),
    .in_x        (in_chan.x_component),
    .in_y        (in_chan.y_component),
    .in_z        (in_chan.z_component),
    .sts         (sts),
    .out_angle_z (out_chan.angle_z),
    .out_angle_y (out_chan.angle_y)
  );

endmodule
